// ===== src/stpi_pkg.sv =====
// shared types and constants for the trapezoid step interval block
// no dependencies; used by every module of the block except stpi_div_cell
`default_nettype none
package stpi_pkg;

  localparam int unsigned IdxW  = 31;
  localparam int unsigned IvW   = 20;
  localparam int unsigned FreqW = 32;

  localparam logic [IvW-1:0] ONE_MILLION = 20'd1000000;

  // register indexes on the configuration port
  localparam logic [1:0] REG_TOTAL  = 2'd0;
  localparam logic [1:0] REG_RAMP   = 2'd1;
  localparam logic [1:0] REG_START  = 2'd2;
  localparam logic [1:0] REG_CRUISE = 2'd3;

  // reset values of the registers and of the derived frequencies
  localparam logic [IdxW-1:0] RST_TOTAL  = 31'd1;
  localparam logic [IdxW-1:0] RST_RAMP   = 31'd1;
  localparam logic [IvW-1:0]  RST_START  = 20'd2000;
  localparam logic [IvW-1:0]  RST_CRUISE = 20'd500;
  localparam logic [IvW-1:0]  RST_F0     = 20'd500;
  localparam logic [IvW-1:0]  RST_FC     = 20'd2000;

  // clamped profile view handed from the register block to the datapath
  typedef struct packed {
    logic [IdxW-1:0] total;
    logic [IdxW-1:0] accel;
    logic [IvW-1:0]  f0;
    logic [IvW-1:0]  fc;
    logic [IvW-1:0]  cruise;
    logic            busy;
  } cfg_view_t;

endpackage
`default_nettype wire

// ===== src/stpi_div_cell.sv =====
// one restoring division cell: retires one quotient bit per cycle while en is high
// uses no package; chained in the datapath of the top level
`default_nettype none
module stpi_div_cell #(
  parameter int unsigned DW  = 31,
  parameter int unsigned SW  = 32,
  parameter int unsigned SBW = 1
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           en,
  input  wire logic           in_valid,
  input  wire logic [DW-1:0]  in_rem,
  input  wire logic [SW-1:0]  in_sh,
  input  wire logic [SBW-1:0] in_sb,
  input  wire logic [DW-1:0]  div,
  output logic                out_valid_r,
  output logic [DW-1:0]       out_rem_r,
  output logic [SW-1:0]       out_sh_r,
  output logic [SBW-1:0]      out_sb_r
);

  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          ge;
  logic [DW-1:0] rem_nxt;
  logic [SW-1:0] sh_nxt;

  // bring down the next dividend bit and try the subtract
  always_comb begin
    trial   = {in_rem, in_sh[SW-1]};
    diff    = trial - {1'b0, div};
    ge      = (trial >= {1'b0, div});
    rem_nxt = ge ? diff[DW-1:0] : trial[DW-1:0];
    sh_nxt  = {in_sh[SW-2:0], ge};
  end

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= in_valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (en) begin
      out_rem_r <= rem_nxt;
      out_sh_r  <= sh_nxt;
      out_sb_r  <= in_sb;
    end
  end

endmodule
`default_nettype wire

// ===== src/stpi_freq_div.sv =====
// serial divider turning an interval register into 1000000/interval
// depends on stpi_pkg for widths and the constant
`default_nettype none
module stpi_freq_div #(
  parameter logic [stpi_pkg::IvW-1:0] RESET_Q = stpi_pkg::RST_F0
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  input  wire logic [stpi_pkg::IvW-1:0] value,
  output logic [stpi_pkg::IvW-1:0]      freq_r,
  output logic                          busy_r
);

  logic [stpi_pkg::IvW-1:0] div_r;
  logic [stpi_pkg::IvW-1:0] rem_r;
  logic [stpi_pkg::IvW-1:0] sh_r;
  logic [4:0]               cnt_r;
  logic [stpi_pkg::IvW:0]   trial;
  logic [stpi_pkg::IvW:0]   diff;
  logic                     ge;
  logic [stpi_pkg::IvW-1:0] rem_nxt;
  logic [stpi_pkg::IvW-1:0] sh_nxt;

  // one quotient bit a cycle while busy
  always_comb begin
    trial   = {rem_r, sh_r[stpi_pkg::IvW-1]};
    diff    = trial - {1'b0, div_r};
    ge      = (trial >= {1'b0, div_r});
    rem_nxt = ge ? diff[stpi_pkg::IvW-1:0] : trial[stpi_pkg::IvW-1:0];
    sh_nxt  = {sh_r[stpi_pkg::IvW-2:0], ge};
  end

  // control and result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      freq_r <= RESET_Q;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 5'd1;
      if (cnt_r == 5'(stpi_pkg::IvW - 1)) begin
        busy_r <= 1'b0;
        freq_r <= sh_nxt;
      end
    end
  end

  // working registers; a zero interval divides as one
  always_ff @(posedge clk) begin
    if (start) begin
      div_r <= (value == '0) ? stpi_pkg::IvW'(1) : value;
      rem_r <= '0;
      sh_r  <= stpi_pkg::ONE_MILLION;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      sh_r  <= sh_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== src/stpi_cfg.sv =====
// configuration registers, clamped ramp length and endpoint frequencies
// depends on stpi_pkg and stpi_freq_div
`default_nettype none
module stpi_cfg (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output stpi_pkg::cfg_view_t view
);

  logic [stpi_pkg::IdxW-1:0] total_r;
  logic [stpi_pkg::IdxW-1:0] ramp_r;
  logic [stpi_pkg::IvW-1:0]  start_r;
  logic [stpi_pkg::IvW-1:0]  cruise_r;
  logic                      wr;
  logic [1:0]                idx;
  logic [stpi_pkg::IdxW-1:0] total_c;
  logic [stpi_pkg::IdxW-1:0] half;
  logic [stpi_pkg::IdxW-1:0] acc1;
  logic [stpi_pkg::IdxW-1:0] acc2;
  logic [stpi_pkg::IvW-1:0]  f0;
  logic [stpi_pkg::IvW-1:0]  fc;
  logic                      busy0;
  logic                      busy1;

  assign wr  = psel && penable && pwrite;
  assign idx = paddr[3:2];

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r  <= stpi_pkg::RST_TOTAL;
      ramp_r   <= stpi_pkg::RST_RAMP;
      start_r  <= stpi_pkg::RST_START;
      cruise_r <= stpi_pkg::RST_CRUISE;
    end else if (wr) begin
      unique case (idx)
        stpi_pkg::REG_TOTAL:  total_r  <= pwdata[stpi_pkg::IdxW-1:0];
        stpi_pkg::REG_RAMP:   ramp_r   <= pwdata[stpi_pkg::IdxW-1:0];
        stpi_pkg::REG_START:  start_r  <= pwdata[stpi_pkg::IvW-1:0];
        stpi_pkg::REG_CRUISE: cruise_r <= pwdata[stpi_pkg::IvW-1:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    unique case (idx)
      stpi_pkg::REG_TOTAL:  prdata = {1'b0, total_r};
      stpi_pkg::REG_RAMP:   prdata = {1'b0, ramp_r};
      stpi_pkg::REG_START:  prdata = {12'd0, start_r};
      stpi_pkg::REG_CRUISE: prdata = {12'd0, cruise_r};
      default:              prdata = '0;
    endcase
  end

  // endpoint frequencies, recomputed after each interval write
  stpi_freq_div #(.RESET_Q(stpi_pkg::RST_F0)) u_f0 (
    .clk(clk), .rst_n(rst_n),
    .start(wr && idx == stpi_pkg::REG_START),
    .value(pwdata[stpi_pkg::IvW-1:0]),
    .freq_r(f0), .busy_r(busy0)
  );

  stpi_freq_div #(.RESET_Q(stpi_pkg::RST_FC)) u_fc (
    .clk(clk), .rst_n(rst_n),
    .start(wr && idx == stpi_pkg::REG_CRUISE),
    .value(pwdata[stpi_pkg::IvW-1:0]),
    .freq_r(fc), .busy_r(busy1)
  );

  // clamp total to one and ramp to between one and half the total
  always_comb begin
    total_c = (total_r == '0) ? stpi_pkg::IdxW'(1) : total_r;
    half    = total_c >> 1;
    acc1    = (ramp_r == '0) ? stpi_pkg::IdxW'(1) : ramp_r;
    acc2    = (acc1 > half) ? half : acc1;
    view.total  = total_c;
    view.accel  = (acc2 == '0) ? stpi_pkg::IdxW'(1) : acc2;
    view.f0     = f0;
    view.fc     = fc;
    view.cruise = cruise_r;
    view.busy   = busy0 || busy1;
  end

endmodule
`default_nettype wire

// ===== src/trapezoid_step_interval.sv =====
// top level: step index in, step interval out, through two division chains
// depends on stpi_pkg, stpi_cfg and stpi_div_cell
//
// channel   dir  handshake                  payload
// in_       in   in_tvalid/in_tready        in_tdata = step_index (signed 32)
// out_      out  out_tvalid/out_tready      out_tdata = interval_us, out_tuser = freq_fault
// cfg_      in   cfg_psel/penable/pwrite    4 registers at byte addresses 0,4,8,12
//
// one request per cycle unless stalled as below; 3 front stages, 32 ramp-division
// cells, one sum stage, 20 inversion cells, one output register
// the whole chain advances unless the output holds a result not yet taken
// an interval register write recomputes its frequency serially;
// in_tready stays low until that is done
// reset is synchronous and clears all valid flags
`default_nettype none
module trapezoid_step_interval (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,    // [31:0] step_index
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,   // [19:0] interval_us, [23:20] zero
  output logic             out_tuser,   // [0] freq_fault
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  localparam int unsigned N1 = 32;
  localparam int unsigned N2 = stpi_pkg::IvW;
  localparam int unsigned IW = stpi_pkg::IdxW;

  stpi_pkg::cfg_view_t cv;
  logic en;
  logic acc;

  logic          a_valid_r;
  logic [IW-1:0] a_idx_r;
  logic [IW-1:0] a_idx_nxt;
  logic          b_valid_r;
  logic [IW-1:0] b_i_r;
  logic          b_ramp_r;
  logic [IW-1:0] mirror_idx;
  logic          c_valid_r;
  logic [62:0]   c_prod_r;
  logic          c_ramp_r;
  logic [31:0]   diff;

  logic          v1  [0:N1];
  logic [IW-1:0] r1  [0:N1];
  logic [31:0]   s1  [0:N1];
  logic [0:0]    sb1 [0:N1];

  logic          d_valid_r;
  logic [31:0]   d_f_r;
  logic          d_fault_r;
  logic          d_ramp_r;
  logic [31:0]   f_sum;

  logic          v2  [0:N2];
  logic [31:0]   r2  [0:N2];
  logic [N2-1:0] s2  [0:N2];
  logic [33:0]   sb2 [0:N2];

  logic                      out_valid_r;
  logic [stpi_pkg::IvW-1:0]  out_iv_r;
  logic                      out_fault_r;
  logic [stpi_pkg::IvW-1:0]  iv_nxt;

  stpi_cfg u_cfg (
    .clk(clk), .rst_n(rst_n),
    .psel(cfg_psel), .penable(cfg_penable), .pwrite(cfg_pwrite),
    .paddr(cfg_paddr), .pwdata(cfg_pwdata), .prdata(cfg_prdata),
    .view(cv)
  );
  assign cfg_pready = 1'b1;

  assign en        = !out_valid_r || out_tready;
  assign in_tready = rst_n && en && !cv.busy;
  assign acc       = in_tvalid && in_tready;

  // clamp the index into the move
  always_comb begin
    if (in_tdata[31]) begin
      a_idx_nxt = '0;
    end else if (in_tdata[IW-1:0] >= cv.total) begin
      a_idx_nxt = cv.total - IW'(1);
    end else begin
      a_idx_nxt = in_tdata[IW-1:0];
    end
  end

  // mirror from the nearer end and the wrapped frequency span
  assign mirror_idx = cv.total - IW'(1) - a_idx_r;
  assign diff       = {12'd0, cv.fc} - {12'd0, cv.f0};

  // front stage valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
      c_valid_r <= 1'b0;
      d_valid_r <= 1'b0;
    end else if (en) begin
      a_valid_r <= acc;
      b_valid_r <= a_valid_r;
      c_valid_r <= b_valid_r;
      d_valid_r <= v1[N1];
    end
  end

  // front stage payload
  always_ff @(posedge clk) begin
    if (en) begin
      a_idx_r  <= a_idx_nxt;
      b_i_r    <= (a_idx_r < mirror_idx) ? a_idx_r : mirror_idx;
      b_ramp_r <= ((a_idx_r < mirror_idx) ? a_idx_r : mirror_idx) < cv.accel;
      c_prod_r <= diff * b_i_r;
      c_ramp_r <= b_ramp_r;
      d_f_r     <= f_sum;
      d_fault_r <= (f_sum == '0);
      d_ramp_r  <= sb1[N1][0];
    end
  end

  // ramp division: span * i / accel, one quotient bit per cell
  assign v1[0]  = c_valid_r;
  assign r1[0]  = c_prod_r[62:32];
  assign s1[0]  = c_prod_r[31:0];
  assign sb1[0] = c_ramp_r;

  for (genvar k = 0; k < N1; k++) begin : g_ramp
    stpi_div_cell #(.DW(IW), .SW(32), .SBW(1)) u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .in_valid(v1[k]), .in_rem(r1[k]), .in_sh(s1[k]), .in_sb(sb1[k]),
      .div(cv.accel),
      .out_valid_r(v1[k+1]), .out_rem_r(r1[k+1]), .out_sh_r(s1[k+1]),
      .out_sb_r(sb1[k+1])
    );
  end

  assign f_sum = {12'd0, cv.f0} + s1[N1];

  // inversion: 1000000 / f, the divisor rides along with each request
  assign v2[0]  = d_valid_r;
  assign r2[0]  = '0;
  assign s2[0]  = stpi_pkg::ONE_MILLION;
  assign sb2[0] = {d_f_r, d_fault_r, d_ramp_r};

  for (genvar k = 0; k < N2; k++) begin : g_inv
    stpi_div_cell #(.DW(32), .SW(N2), .SBW(34)) u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .in_valid(v2[k]), .in_rem(r2[k]), .in_sh(s2[k]), .in_sb(sb2[k]),
      .div(sb2[k][33:2]),
      .out_valid_r(v2[k+1]), .out_rem_r(r2[k+1]), .out_sh_r(s2[k+1]),
      .out_sb_r(sb2[k+1])
    );
  end

  // pick cruise, saturated or inverted interval
  always_comb begin
    if (!sb2[N2][0]) begin
      iv_nxt = cv.cruise;
    end else if (sb2[N2][1]) begin
      iv_nxt = stpi_pkg::ONE_MILLION;
    end else begin
      iv_nxt = s2[N2];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= v2[N2];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_iv_r    <= iv_nxt;
      out_fault_r <= sb2[N2][0] && sb2[N2][1];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_iv_r};
  assign out_tuser  = out_fault_r;

  // no request is taken while a frequency is being recomputed
  a_busy_block: assert property (@(posedge clk) disable iff (!rst_n)
    cv.busy |-> !in_tready)
    else $error("request accepted during frequency update");

  // a fault result always carries the saturated interval
  a_fault_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tdata[19:0] == stpi_pkg::ONE_MILLION))
    else $error("fault without saturated interval");

  // the chain holds still while a result waits
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> ($stable(d_valid_r) && $stable(a_valid_r)))
    else $error("pipeline moved under a stalled output");

  // reset leaves no result behind
  a_rst: assert property (@(posedge clk)
    !$past(rst_n) |-> !out_tvalid)
    else $error("result valid right after reset");

endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
// testbench for trapezoid_step_interval: drives step indexes, checks intervals
// depends on stpi_pkg and the trapezoid_step_interval rtl
`default_nettype none

// profile predictor and expected-interval store
class interval_board;
  bit [30:0] total_reg;
  bit [30:0] ramp_reg;
  bit [19:0] start_reg;
  bit [19:0] cruise_reg;
  bit [19:0] exp_iv_q[$];
  bit        exp_fault_q[$];
  int        errors;

  function new();
    total_reg = stpi_pkg::RST_TOTAL;
    ramp_reg = stpi_pkg::RST_RAMP;
    start_reg = stpi_pkg::RST_START;
    cruise_reg = stpi_pkg::RST_CRUISE;
    errors = 0;
  endfunction

  function void set_reg(logic [1:0] idx, bit [31:0] val);
    case (idx)
      stpi_pkg::REG_TOTAL:  total_reg = val[30:0];
      stpi_pkg::REG_RAMP:   ramp_reg = val[30:0];
      stpi_pkg::REG_START:  start_reg = val[19:0];
      default:              cruise_reg = val[19:0];
    endcase
  endfunction

  function bit [31:0] rate_of(bit [19:0] iv);
    bit [31:0] d;
    d = (iv == 0) ? 32'd1 : {12'd0, iv};
    return 32'd1000000 / d;
  endfunction

  // note an accepted step index and work out its interval
  function void note_index(bit [31:0] raw);
    bit [31:0] tot, acc, idx, rev_idx, i, f0, fc, f, iv;
    bit [63:0] prod;
    bit        flt;
    tot = (total_reg < 1) ? 32'd1 : {1'b0, total_reg};
    acc = (ramp_reg < 1) ? 32'd1 : {1'b0, ramp_reg};
    if (acc > tot / 2) acc = tot / 2;
    if (acc < 1) acc = 1;
    if (raw[31]) idx = 0;
    else if (raw >= tot) idx = tot - 1;
    else idx = raw;
    rev_idx = tot - 1 - idx;
    i = (idx < rev_idx) ? idx : rev_idx;
    flt = 0;
    if (i >= acc) begin
      iv = {12'd0, cruise_reg};
    end else begin
      f0 = rate_of(start_reg);
      fc = rate_of(cruise_reg);
      prod = {32'd0, fc - f0} * {32'd0, i};
      f = f0 + 32'(prod / {32'd0, acc});
      if (f == 0) begin
        iv = 32'd1000000;
        flt = 1;
      end else begin
        iv = 32'd1000000 / f;
      end
    end
    exp_iv_q.push_back(iv[19:0]);
    exp_fault_q.push_back(flt);
  endfunction

  // compare one accepted result with the oldest expectation
  function void check_interval(bit [23:0] data, bit fault);
    bit [19:0] e_iv;
    bit        e_flt;
    if (exp_iv_q.size() == 0) begin
      $error("unexpected result interval_us=%0d", data[19:0]);
      errors++;
      return;
    end
    e_iv = exp_iv_q.pop_front();
    e_flt = exp_fault_q.pop_front();
    if (data[19:0] !== e_iv) begin
      $error("interval_us expected %0d got %0d", e_iv, data[19:0]);
      errors++;
    end
    if (fault !== e_flt) begin
      $error("freq_fault expected %0d got %0d", e_flt, fault);
      errors++;
    end
    if (data[23:20] !== 4'd0) begin
      $error("tdata pad expected 0 got %0d", data[23:20]);
      errors++;
    end
  endfunction
endclass

module tb_top;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;
  logic        out_tuser;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [3:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  interval_board board;
  bit            rx_enable;

  trapezoid_step_interval u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata),
    .cfg_prdata(cfg_prdata), .cfg_pready(cfg_pready)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
    return 0;
  endfunction

  // result side: random stalls, check on each handshake
  always @(posedge clk) begin
    if (out_tvalid && out_tready) board.check_interval(out_tdata, out_tuser);
  end

  initial begin
    int stall;
    out_tready = 1'b0;
    wait (rx_enable);
    forever begin
      stall = gap_len();
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk);
    end
  end

  // one register write: setup cycle then access cycle
  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    board.set_reg(idx, val);
  endtask

  // one step index request, waiting for acceptance
  task automatic send_index(logic [31:0] val, bit no_gap);
    int g;
    g = no_gap ? 0 : gap_len();
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= val;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.note_index(val);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (board.exp_iv_q.size() != 0) @(posedge clk);
    repeat (70) @(posedge clk);
  endtask

  task automatic set_profile(logic [31:0] tot, logic [31:0] rmp,
                             logic [31:0] st, logic [31:0] cr);
    drain();
    write_reg(stpi_pkg::REG_TOTAL, tot);
    write_reg(stpi_pkg::REG_RAMP, rmp);
    write_reg(stpi_pkg::REG_START, st);
    write_reg(stpi_pkg::REG_CRUISE, cr);
  endtask

  function automatic logic [31:0] pick_index(logic [30:0] tot);
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return 32'h8000_0000 | $urandom();
      2: return {1'b0, tot} + $urandom_range(0, 3);
      default: return (tot == 0) ? 32'd0 : $urandom_range(0, tot - 1);
    endcase
  endfunction

  function automatic logic [31:0] pick_iv();
    case ($urandom_range(0, 7))
      0: return $urandom_range(0, 3);
      1: return 32'd1000000 + $urandom_range(0, 3);
      2: return $urandom_range(0, 20'hFFFFF);
      3: return $urandom();
      default: return $urandom_range(1, 20000);
    endcase
  endfunction

  initial begin
    logic [31:0] dir_idx[$];
    logic [31:0] tot, rmp;
    board = new();
    rx_enable = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    rx_enable = 1;

    // reset profile: one-step move
    send_index(32'd0, 0);
    send_index(32'h8000_0000, 0);

    // directed: ramp of 4 in a move of 10, index extremes
    set_profile(32'd10, 32'd4, 32'd2000, 32'd500);
    dir_idx = '{32'd0, 32'd1, 32'd3, 32'd4, 32'd5, 32'd8, 32'd9, 32'd10,
                32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h5555_5555,
                32'hAAAA_AAAA};
    foreach (dir_idx[k]) send_index(dir_idx[k], 0);
    // zero intervals, zero total and ramp, high register bits dropped
    set_profile(32'h8000_0000, 32'h0, 32'hFFF0_0000, 32'h0);
    send_index(32'd0, 0);
    // large intervals give frequency zero: fault
    set_profile(32'd100, 32'd50, 32'd1000001, 32'd1048575);
    send_index(32'd3, 0);
    send_index(32'd60, 0);
    // start faster than cruise wraps the difference; ramp clamped to half the move
    set_profile(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd1, 32'd1000000);
    send_index(32'd12345, 0);
    send_index(32'h3FFF_FFFF, 0);
    send_index(32'h7FFF_FFFE, 0);

    // random phases
    for (int ph = 0; ph < 20; ph++) begin
      tot = ($urandom_range(0, 4) == 0) ? $urandom() : $urandom_range(0, 300);
      rmp = ($urandom_range(0, 4) == 0) ? $urandom() : $urandom_range(0, tot);
      set_profile(tot, rmp, pick_iv(), pick_iv());
      for (int n = 0; n < 50; n++) begin
        send_index(pick_index(board.total_reg), (ph % 4) == 1);
        if (ph == 3 && n == 25) drain();
      end
    end

    drain();
    if (board.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("*** FAILED ***");
    $finish;
  end
endmodule

`default_nettype wire

// ===== filelist.f =====
src/stpi_pkg.sv
src/stpi_div_cell.sv
src/stpi_freq_div.sv
src/stpi_cfg.sv
src/trapezoid_step_interval.sv
verif/tb_top.sv
